// File: rtl/core/frustum_cull_test_unit_defines.svh
// ----------------------------------------------------------------------------
// frustum_cull_test_unit_defines.svh
// assertion macros shared by the frustum cull checker
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH
`define FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frustum cull check failed");

// next-cycle implication, disabled in reset
`define FCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frustum cull check failed");

`endif

// File: rtl/core/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// types and constants of the frustum cull test unit
// ----------------------------------------------------------------------------
package fct_pkg;

   localparam int unsigned PLANE_COUNT = 5;
   localparam int unsigned SLOT_W      = 3;
   localparam int unsigned PIDX_W      = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int unsigned COORD_W     = 32;
   localparam int unsigned EXT_W       = COORD_W + 1;
   localparam int unsigned TERM_W      = COORD_W + 2;
   localparam int unsigned PROD_W      = 2 * COORD_W;
   localparam int unsigned DIST_W      = PROD_W + 3;
   localparam int unsigned FRAC_SHIFT  = 29;

   localparam logic [SLOT_W-1:0] FAIL_NONE = SLOT_W'(PLANE_COUNT);

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_POINT  = 2'd1;
   localparam logic [1:0] OP_SPHERE = 2'd2;
   localparam logic [1:0] OP_VERTEX = 2'd3;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic [SLOT_W-1:0]          plane_slot;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic signed [COORD_W-1:0]  coord_z;
      logic signed [COORD_W-1:0]  scalar_term;
      logic                       last_vertex;
   } req_type;

   typedef struct packed {
      logic              inside_res;
      logic [SLOT_W-1:0] failing_plane;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] nx;
      logic signed [COORD_W-1:0] ny;
      logic signed [COORD_W-1:0] nz;
      logic signed [COORD_W-1:0] d_term;
   } plane_type;

   typedef struct packed {
      logic is_vertex;
      logic first;
      logic last;
   } kind_type;

endpackage

// File: rtl/core/frustum_cull_test_unit.sv
// ----------------------------------------------------------------------------
// frustum_cull_test_unit: point, sphere and polygon test against five planes
// pipeline: a result passes the request, product and result registers in order
// throughput: one request per cycle while the result is not stalled, set by fifteen parallel 32x32 multipliers
// reset: synchronous, clears pipeline valids, hit flags and polygon state
// ----------------------------------------------------------------------------
module frustum_cull_test_unit
   import fct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // plane table, undefined until loaded
   plane_type plane_ff [PLANE_COUNT];

   // polygon tracking at the input side
   logic                      poly_open_ff, poly_open_in;
   logic signed [COORD_W-1:0] held_offset_ff, held_offset_in;

   // stage one: registered request
   logic                      s1_valid_ff, s1_valid_in;
   kind_type                  s1_kind_ff;
   logic signed [COORD_W-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic signed [EXT_W-1:0]   s1_ext_ff;

   // stage two: registered products and constant terms
   logic                      s2_valid_ff, s2_valid_in;
   kind_type                  s2_kind_ff;
   logic signed [PROD_W-1:0]  prod_ff [PLANE_COUNT][3];
   logic signed [TERM_W-1:0]  term_ff [PLANE_COUNT];

   // polygon hit flags and result register
   logic [PLANE_COUNT-1:0]    hit_flags_ff, hit_flags_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff;

   logic                      req_go;
   logic                      s1_en;
   logic                      s2_free;
   logic                      s2_go;
   logic                      out_free;
   logic                      load_hit;
   logic                      first_vertex;
   logic signed [COORD_W-1:0] eff_offset;
   logic signed [EXT_W-1:0]   ext_in;
   kind_type                  kind_in;

   logic signed [PROD_W-1:0]  prod_in [PLANE_COUNT][3];
   logic signed [TERM_W-1:0]  term_in [PLANE_COUNT];
   logic signed [DIST_W-1:0]  dist_sum [PLANE_COUNT];
   logic [PLANE_COUNT-1:0]    neg_vec;
   logic [PLANE_COUNT-1:0]    pos_vec;
   logic [PLANE_COUNT-1:0]    flags_new;
   logic [PLANE_COUNT-1:0]    fail_vec;
   logic                      has_result;
   logic [SLOT_W-1:0]         fail_idx;

   // ---------------------------------------------------------------- handshake
   // each stage moves when the one after it is empty or moving
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign has_result = !s2_kind_ff.is_vertex || s2_kind_ff.last;
   assign s2_go     = s2_valid_ff && (!has_result || out_free);
   assign s2_free   = !s2_valid_ff || s2_go;
   assign s1_en     = !s1_valid_ff || s2_free;
   assign req_ready = s1_en;
   assign req_go    = req_valid && req_ready;

   // ---------------------------------------------------------------- input decode
   assign load_hit = req_go && (req_data.opcode == OP_LOAD)
                     && ({1'b0, req_data.plane_slot} < (SLOT_W + 1)'(PLANE_COUNT));

   always_comb begin
      first_vertex   = !poly_open_ff;
      eff_offset     = first_vertex ? req_data.scalar_term : held_offset_ff;
      poly_open_in   = poly_open_ff;
      held_offset_in = held_offset_ff;
      kind_in.is_vertex = (req_data.opcode == OP_VERTEX);
      kind_in.first     = first_vertex;
      kind_in.last      = req_data.last_vertex;

      // extra constant term: +radius for a sphere, -offset for a vertex
      unique case (req_data.opcode)
         OP_SPHERE: ext_in = EXT_W'(req_data.scalar_term);
         OP_VERTEX: ext_in = -EXT_W'(eff_offset);
         default:   ext_in = '0;
      endcase

      // first vertex opens the polygon and latches the offset
      if (req_go && (req_data.opcode == OP_VERTEX)) begin
         poly_open_in = !req_data.last_vertex;
         if (first_vertex) begin
            held_offset_in = req_data.scalar_term;
         end
      end

      if (s1_en) begin
         s1_valid_in = req_go && (req_data.opcode != OP_LOAD);
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // plane writes land at accept, so later requests see the new plane
   always_ff @(posedge clock) begin
      if (load_hit) begin
         plane_ff[req_data.plane_slot[PIDX_W-1:0]] <= '{
            nx:     req_data.coord_x,
            ny:     req_data.coord_y,
            nz:     req_data.coord_z,
            d_term: req_data.scalar_term
         };
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_open_ff   <= 1'b0;
         held_offset_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         poly_open_ff   <= poly_open_in;
         held_offset_ff <= held_offset_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_kind_ff <= kind_in;
         s1_x_ff    <= req_data.coord_x;
         s1_y_ff    <= req_data.coord_y;
         s1_z_ff    <= req_data.coord_z;
         s1_ext_ff  <= ext_in;
      end
   end

   // ---------------------------------------------------------------- stage one
   // three products per plane, plus the plane's d term merged with the extra term
   always_comb begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
         prod_in[i][0] = PROD_W'(s1_x_ff) * PROD_W'(plane_ff[i].nx);
         prod_in[i][1] = PROD_W'(s1_y_ff) * PROD_W'(plane_ff[i].ny);
         prod_in[i][2] = PROD_W'(s1_z_ff) * PROD_W'(plane_ff[i].nz);
         term_in[i]    = TERM_W'(plane_ff[i].d_term) + TERM_W'(s1_ext_ff);
      end
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_kind_ff <= s1_kind_ff;
         prod_ff    <= prod_in;
         term_ff    <= term_in;
      end
   end

   // ---------------------------------------------------------------- stage two
   // exact signed distance with 58 fractional bits, then sign tests
   always_comb begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
         dist_sum[i] = DIST_W'(prod_ff[i][0]) + DIST_W'(prod_ff[i][1])
                     + DIST_W'(prod_ff[i][2]) + (DIST_W'(term_ff[i]) <<< FRAC_SHIFT);
         neg_vec[i] = dist_sum[i][DIST_W-1];
         pos_vec[i] = !dist_sum[i][DIST_W-1] && (dist_sum[i] != '0);
      end

      // a new polygon starts from cleared flags
      flags_new = (s2_kind_ff.first ? '0 : hit_flags_ff) | pos_vec;
      fail_vec  = s2_kind_ff.is_vertex ? ~flags_new : neg_vec;

      // lowest failing plane wins
      fail_idx = FAIL_NONE;
      for (int i = PLANE_COUNT - 1; i >= 0; i--) begin
         if (fail_vec[i]) begin
            fail_idx = SLOT_W'(i);
         end
      end

      hit_flags_in = hit_flags_ff;
      if (s2_go && s2_kind_ff.is_vertex) begin
         hit_flags_in = flags_new;
      end

      if (s2_go && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_flags_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_flags_ff <= hit_flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pass comes from the failure vector, so it holds for any plane count
   always_ff @(posedge clock) begin
      if (s2_go && has_result) begin
         rsp_data_ff.inside_res    <= (fail_vec == '0);
         rsp_data_ff.failing_plane <= fail_idx;
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/fct_checker.sv
// ----------------------------------------------------------------------------
// fct_checker
// port-level checks on the frustum cull test unit, bound to the top level
// ----------------------------------------------------------------------------
`include "frustum_cull_test_unit_defines.svh"

module fct_checker
   import fct_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result stays up
   `FCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // stalled result keeps its payload
   `FCT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))

   // pass flag agrees with the failing plane index
   `FCT_ASSERT_NOW(a_pass_code, clock, reset, rsp_valid, rsp_data.inside_res == (rsp_data.failing_plane == FAIL_NONE))

   // no failing plane index beyond the table
   `FCT_ASSERT_NOW(a_plane_range, clock, reset, rsp_valid, rsp_data.failing_plane <= FAIL_NONE)

endmodule

bind frustum_cull_test_unit fct_checker u_fct_checker (.*);
